// ===== rtl/rtef_pkg.sv =====
`default_nettype none

package rtef_pkg;

  localparam int unsigned COUNT_W = 32;

  localparam logic [7:0] ST_CLOCK    = 8'hF8;
  localparam logic [7:0] ST_START    = 8'hFA;
  localparam logic [7:0] ST_CONTINUE = 8'hFB;
  localparam logic [7:0] ST_STOP     = 8'hFC;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic [7:0]  status;
    logic [7:0]  source;
    logic [31:0] tstamp;
  } event_t;

  // Per-transaction outcome handed from the pointer logic to the result stage.
  typedef struct packed {
    logic pop_hit;
    logic push_taken;
  } flags_t;

  function automatic logic is_realtime(input logic [7:0] s);
    logic r;
    case (s) inside
      ST_CLOCK, ST_START, ST_CONTINUE, ST_STOP: r = 1'b1;
      default:                                  r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/realtime_event_fifo_drop_oldest.sv =====
`default_nettype none

// Timestamped FIFO for MIDI realtime events that drops the oldest entry on
// overflow. A transaction is taken at every clock edge where start is high
// (busy stays low), one per cycle, and its result appears on the out_ ports
// with out_strobe for exactly the following cycle, its data taken from the
// registered read port of the event memory. The receiver cannot
// stall, so results must be captured when out_strobe is high. Pushes of
// statuses other than clock, start, continue and stop are ignored
// (out_push_taken low). The ring holds RING_DEPTH-1 events; out_lost_count
// reports the wrapping number of events discarded so far.
module realtime_event_fifo_drop_oldest #(
  parameter int unsigned RING_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_op,
  input  wire logic [7:0]  in_status_byte,
  input  wire logic [7:0]  in_source_tag,
  input  wire logic [31:0] in_time_stamp,
  output logic             out_strobe,
  output logic             out_event_valid,
  output logic [7:0]       out_event_status,
  output logic [7:0]       out_event_source,
  output logic [31:0]      out_event_time,
  output logic             out_push_taken,
  output logic [31:0]      out_lost_count
);

  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  logic                         accept;
  logic                         wr_en, rd_en;
  logic [AW-1:0]                wr_addr, rd_addr;
  rtef_pkg::flags_t             flags, flags_r;
  rtef_pkg::event_t             wr_data, rd_data;
  logic [rtef_pkg::COUNT_W-1:0] lost_count;
  logic                         strobe_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign wr_data.status = in_status_byte;
  assign wr_data.source = in_source_tag;
  assign wr_data.tstamp = in_time_stamp;

  rtef_ctrl #(
    .RING_DEPTH (RING_DEPTH),
    .AW         (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .op          (in_op),
    .status_byte (in_status_byte),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .flags       (flags),
    .lost_count  (lost_count)
  );

  rtef_store #(
    .RING_DEPTH (RING_DEPTH),
    .AW         (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
      flags_r  <= '0;
    end else begin
      strobe_r <= accept;
      flags_r  <= accept ? flags : '0;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_event_valid  = flags_r.pop_hit;
  assign out_event_status = flags_r.pop_hit ? rd_data.status : 8'd0;
  assign out_event_source = flags_r.pop_hit ? rd_data.source : 8'd0;
  assign out_event_time   = flags_r.pop_hit ? rd_data.tstamp : 32'd0;
  assign out_push_taken   = flags_r.push_taken;
  assign out_lost_count   = lost_count;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_strobe)
    else $error("accepted transaction produced no result");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_event_valid && out_push_taken))
    else $error("result marks both a popped event and a taken push");

  a_flags_need_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_event_valid || out_push_taken) |-> out_strobe)
    else $error("result flags raised without a strobe");

  a_lost_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_lost_count == $past(out_lost_count)
                      || out_lost_count == $past(out_lost_count) + 32'd1))
    else $error("lost count moved by more than one");

endmodule

`default_nettype wire

// ===== rtl/rtef_store.sv =====
`default_nettype none

module rtef_store #(
  parameter int unsigned RING_DEPTH = 32,
  parameter int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire rtef_pkg::event_t  wr_data,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output rtef_pkg::event_t       rd_data
);

  rtef_pkg::event_t mem_r [RING_DEPTH];
  rtef_pkg::event_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/rtef_ctrl.sv =====
`default_nettype none

module rtef_ctrl #(
  parameter int unsigned RING_DEPTH = 32,
  parameter int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         accept,
  input  wire logic                         op,
  input  wire logic [7:0]                   status_byte,
  output logic                              wr_en,
  output logic [AW-1:0]                     wr_addr,
  output logic                              rd_en,
  output logic [AW-1:0]                     rd_addr,
  output rtef_pkg::flags_t                  flags,
  output logic [rtef_pkg::COUNT_W-1:0]      lost_count
);

  localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);

  logic [AW-1:0]                wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]                rd_ptr_r, rd_ptr_nxt;
  logic [rtef_pkg::COUNT_W-1:0] drop_r, drop_nxt;
  logic [AW-1:0]                wr_adv, rd_adv;
  logic                         is_push, is_pop, full, empty;

  assign wr_adv = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
  assign rd_adv = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
  assign full   = (wr_adv == rd_ptr_r);
  assign empty  = (wr_ptr_r == rd_ptr_r);

  assign is_push = accept && (op == rtef_pkg::OP_PUSH) && rtef_pkg::is_realtime(status_byte);
  assign is_pop  = accept && (op == rtef_pkg::OP_POP) && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    drop_nxt   = drop_r;
    if (is_push) begin
      wr_ptr_nxt = wr_adv;
      // A push into a full ring pushes the oldest event out.
      if (full) begin
        rd_ptr_nxt = rd_adv;
        drop_nxt   = drop_r + 1'b1;
      end
    end else if (is_pop) begin
      rd_ptr_nxt = rd_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      drop_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      drop_r   <= drop_nxt;
    end
  end

  assign wr_en            = is_push;
  assign wr_addr          = wr_ptr_r;
  assign rd_en            = is_pop;
  assign rd_addr          = rd_ptr_r;
  assign flags.pop_hit    = is_pop;
  assign flags.push_taken = is_push;
  // Updated at the same edge that captures the result, so it reads as the
  // count after the transaction for the whole cycle the result is shown.
  assign lost_count       = drop_r;

endmodule

`default_nettype wire
